/* hdl/hms_pkg.sv */
`timescale 1ns / 1ps
package hms_pkg;

   localparam int GRID_SIZE = 256;
   localparam int FRAC_BITS = 8;
   localparam int SIDE      = GRID_SIZE + 1;
   localparam int DEPTH     = SIDE * SIDE;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int IDX_W     = $clog2(SIDE);
   localparam int COORD_W   = 12;
   localparam int H_W       = 24;
   localparam int OUT_W     = 25;
   localparam int DIV_N_W   = 35;
   localparam int DIV_D_W   = 17;
   localparam int DIV_Q_W   = DIV_N_W + 1;
   localparam int DIV_STEPS = DIV_N_W;
   localparam int SLOTS     = 5;

   localparam logic [2:0] FN_WRITE = 3'd0;
   localparam logic [2:0] FN_READ  = 3'd1;
   localparam logic [2:0] FN_TRI   = 3'd2;
   localparam logic [2:0] FN_BILIN = 3'd3;
   localparam logic [2:0] FN_MORPH = 3'd4;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [1:0] STAT_REJECT  = 2'd2;

   localparam logic CSR_STEP = 1'b0;
   localparam logic CSR_SPAN = 1'b1;

   localparam logic [15:0] STEP_RESET = 16'd13;
   localparam logic [22:0] SPAN_RESET = 23'd2560000;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_READ,
      S_WAIT,
      S_LERP,
      S_MUL,
      S_DIV,
      S_WMUL,
      S_STORE,
      S_FINISH,
      S_DONE
   } state_type;

endpackage

/* hdl/hms_req_if.sv */
`timescale 1ns / 1ps
interface hms_req_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  func;
   logic        [9:0]  x_int;
   logic        [9:0]  y_int;
   logic        [7:0]  x_frac;
   logic        [7:0]  y_frac;
   logic signed [23:0] write_height;
   logic        [9:0]  spacing;

   modport source (output valid, func, x_int, y_int, x_frac, y_frac, write_height, spacing,
                   input ready);
   modport sink   (input valid, func, x_int, y_int, x_frac, y_frac, write_height, spacing,
                   output ready);
endinterface

/* hdl/hms_rsp_if.sv */
`timescale 1ns / 1ps
interface hms_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [24:0] height_out;
   logic        [1:0]  status;
   logic signed [23:0] min_height;
   logic signed [23:0] max_height;

   modport source (output valid, height_out, status, min_height, max_height, input ready);
   modport sink   (input valid, height_out, status, min_height, max_height, output ready);
endinterface

/* hdl/hms_div.sv */
`timescale 1ns / 1ps
module hms_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [hms_pkg::DIV_N_W-1:0]   num,
   input  logic        [hms_pkg::DIV_D_W-1:0]   den,
   output logic                                 done,
   output logic signed [hms_pkg::DIV_Q_W-1:0]   quot
);
   import hms_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [5:0]           cnt_ff;
   logic [DIV_N_W-1:0]   mag_ff;
   logic [DIV_D_W:0]     rem_ff;
   logic [DIV_D_W-1:0]   den_ff;
   logic                 neg_ff;
   logic [DIV_D_W:0]     trial;
   logic                 fits;
   logic signed [DIV_Q_W-1:0] mag_s;

   // Restoring division on the magnitude, one quotient bit a cycle.
   always_comb begin
      trial = {rem_ff[DIV_D_W-1:0], mag_ff[DIV_N_W-1]};
      fits  = trial >= {1'b0, den_ff};
      mag_s = $signed({1'b0, mag_ff});
      // Floor division: a negative dividend with a remainder rounds one further down.
      if (neg_ff) begin
         quot = -mag_s - DIV_Q_W'(rem_ff != '0);
      end else begin
         quot = mag_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= num[DIV_N_W-1] ? DIV_N_W'(-num) : DIV_N_W'(num);
         neg_ff <= num[DIV_N_W-1];
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial - {1'b0, den_ff} : trial;
         mag_ff <= {mag_ff[DIV_N_W-2:0], fits};
      end
   end

   assign done = done_ff;

endmodule

/* hdl/heightmap_store_and_sampler.sv */
`timescale 1ns / 1ps
// Height map store and sampler.
// Requests arrive on req_chan (valid/ready); each one yields exactly one response on
// rsp_chan carrying the height, a status code and the current lowest/highest accepted
// heights. Functions: write, raw read, split-triangle sample, bilinear sample and
// morph delta. The user writes registers height_step and max_span through csr_we,
// csr_index and csr_wdata only while no request is in flight; the block does not check.
// After reset the grid memory is cleared by a pass that writes one entry per cycle,
// 66049 entries in all; req_chan.ready stays low until it ends, while register writes
// are taken as usual.
// One request is worked on at a time. A read, morph delta or sample first steps
// through five read slots of the single-port grid memory. A triangle sample also
// passes through the shared divider, which produces one quotient bit per cycle; a
// rounded write uses the same divider. A write with a zero step goes straight to the
// store, and a write, read or sample that is off the grid, a rejected write or an
// unknown function goes straight to the response. Each request ends with a return to
// the idle state before the next one is taken.
// The response sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, a second finished result waits in the sequencer
// until the output register is free.
module heightmap_store_and_sampler (
   input  logic           clock,
   input  logic           reset,
   hms_req_if.sink        req_chan,
   hms_rsp_if.source      rsp_chan,
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic [22:0]    csr_wdata
);
   import hms_pkg::*;

   state_type state_ff, state_in;

   // Grid memory and its port.
   logic [H_W-1:0]    grid_mem [DEPTH];
   logic [H_W-1:0]    mem_q;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [H_W-1:0]    mem_wd;
   logic [ADDR_W-1:0] clr_addr_ff;

   // Configuration and running extremes.
   logic [15:0]           step_ff;
   logic [22:0]           span_ff;
   logic signed [H_W-1:0] low_ff;
   logic signed [H_W-1:0] high_ff;

   // Latched request.
   logic [2:0]            func_ff;
   logic [9:0]            x_ff, y_ff, sp_ff;
   logic [7:0]            dx_ff, dy_ff;
   logic signed [H_W-1:0] h_ff;

   // Read sequencing.
   logic [2:0]            slot_ff;
   logic                  pend_ff;
   logic                  pin_ff;
   logic [2:0]            pslot_ff;
   logic signed [H_W-1:0] v_ff [SLOTS];

   // Datapath.
   logic signed [24:0]    h1_ff, h2_ff;
   logic [8:0]            num_ff, den_ff;
   logic                  tri_ff;
   logic signed [42:0]    prod_ff;
   logic signed [27:0]    res_ff;
   logic [1:0]            status_ff;
   logic [ADDR_W-1:0]     waddr_ff;

   // Response register.
   logic                  rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_h_ff;
   logic [1:0]            rsp_stat_ff;
   logic signed [H_W-1:0] rsp_min_ff, rsp_max_ff;

   // Divider.
   logic                        div_start;
   logic signed [DIV_N_W-1:0]   div_num;
   logic [DIV_D_W-1:0]          div_den;
   logic                        div_done;
   logic signed [DIV_Q_W-1:0]   div_quot;

   logic signed [COORD_W-1:0] cx, cy;
   logic                      slot_use;
   logic                      slot_in;
   logic [ADDR_W-1:0]         slot_addr;
   logic                      xe, ye;
   logic                      req_fire;
   logic                      out_free;

   function automatic logic is_inside(logic signed [COORD_W-1:0] px,
                                      logic signed [COORD_W-1:0] py);
      return px >= 0 && py >= 0 && px <= COORD_W'(GRID_SIZE) && py <= COORD_W'(GRID_SIZE);
   endfunction

   // Edge interpolation along y with a 2^FRAC_BITS denominator.
   function automatic logic signed [24:0] lerp_dy(logic signed [H_W-1:0] a,
                                                  logic signed [H_W-1:0] b,
                                                  logic [7:0] f);
      logic signed [24:0] d;
      logic signed [34:0] p;
      d = 25'(b) - 25'(a);
      p = 35'(d) * $signed({1'b0, f});
      return 25'(a) + 25'(p >>> FRAC_BITS);
   endfunction

   function automatic logic signed [OUT_W-1:0] sat25(logic signed [42:0] v);
      if (v > 43'sd16777215) begin
         return 25'sd16777215;
      end else if (v < -43'sd16777216) begin
         return -25'sd16777216;
      end
      return OUT_W'(v);
   endfunction

   function automatic logic signed [H_W-1:0] sat24(logic signed [42:0] v);
      if (v > 43'sd8388607) begin
         return 24'sd8388607;
      end else if (v < -43'sd8388608) begin
         return -24'sd8388608;
      end
      return H_W'(v);
   endfunction

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign xe = !x_ff[0];
   assign ye = !y_ff[0];

   // Coordinates of the grid entry fetched for each read slot. Slot 0 is the cell
   // origin or the morph center; the others are the cell corners or the coarse
   // neighbours of the morph point.
   always_comb begin
      logic signed [COORD_W-1:0] bx, by, s;
      bx = $signed(COORD_W'(x_ff));
      by = $signed(COORD_W'(y_ff));
      s  = $signed(COORD_W'(sp_ff));
      cx = bx;
      cy = by;
      slot_use = 1'b0;
      case (func_ff)
         FN_READ: begin
            slot_use = (slot_ff == 3'd0);
         end
         FN_TRI, FN_BILIN: begin
            slot_use = (slot_ff != 3'd4);
            cx = bx + COORD_W'(slot_ff[0]);
            cy = by + COORD_W'(slot_ff[1]);
         end
         FN_MORPH: begin
            if (slot_ff == 3'd0) begin
               slot_use = 1'b1;
            end else if (xe && !ye) begin
               slot_use = (slot_ff == 3'd1) || (slot_ff == 3'd2);
               cy = (slot_ff == 3'd1) ? by - s : by + s;
            end else if (!xe && ye) begin
               slot_use = (slot_ff == 3'd1) || (slot_ff == 3'd2);
               cx = (slot_ff == 3'd1) ? bx - s : bx + s;
            end else if (!xe && !ye) begin
               slot_use = 1'b1;
               cx = (slot_ff == 3'd1 || slot_ff == 3'd3) ? bx - s : bx + s;
               cy = (slot_ff == 3'd1 || slot_ff == 3'd4) ? by - s : by + s;
            end
         end
         default: begin
            slot_use = 1'b0;
         end
      endcase
      slot_in   = slot_use && is_inside(cx, cy);
      slot_addr = ADDR_W'(ADDR_W'(cy[IDX_W-1:0]) * ADDR_W'(SIDE)) + ADDR_W'(cx[IDX_W-1:0]);
   end

   // Next state and control.
   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      mem_addr  = slot_addr;
      mem_wd    = '0;
      div_start = 1'b0;
      div_num   = (35'(h_ff) <<< 1) + 35'(step_ff);
      div_den   = {step_ff, 1'b0};
      req_chan.ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_addr_ff;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (func_ff)
               FN_WRITE: begin
                  if (is_inside($signed(COORD_W'(x_ff)), $signed(COORD_W'(y_ff)))) begin
                     if (h_ff < low_ff &&
                         !(26'(high_ff) - 26'(h_ff) < $signed(26'(span_ff)))) begin
                        state_in = S_DONE;
                     end else if (h_ff > high_ff &&
                                  !(26'(h_ff) - 26'(low_ff) < $signed(26'(span_ff)))) begin
                        state_in = S_DONE;
                     end else if (step_ff == '0) begin
                        state_in = S_STORE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
               end
               FN_READ: begin
                  if (is_inside($signed(COORD_W'(x_ff)), $signed(COORD_W'(y_ff)))) begin
                     state_in = S_READ;
                  end
               end
               FN_TRI, FN_BILIN: begin
                  if (x_ff < 10'(GRID_SIZE) && y_ff < 10'(GRID_SIZE)) begin
                     state_in = S_READ;
                  end
               end
               FN_MORPH: begin
                  state_in = S_READ;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            if (slot_ff == 3'(SLOTS - 1)) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_LERP;
         end
         S_LERP: begin
            state_in = (func_ff == FN_TRI || func_ff == FN_BILIN) ? S_MUL : S_DONE;
         end
         S_MUL: begin
            state_in = S_FINISH;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = (func_ff == FN_WRITE) ? S_WMUL : S_DONE;
            end
         end
         S_WMUL: begin
            state_in = S_STORE;
         end
         S_STORE: begin
            mem_we   = 1'b1;
            mem_addr = waddr_ff;
            mem_wd   = sat24(prod_ff);
            state_in = S_DONE;
         end
         S_FINISH: begin
            // The triangle product is registered by now and goes to the divider.
            if (tri_ff) begin
               div_start = 1'b1;
               div_num   = prod_ff[DIV_N_W-1:0];
               div_den   = DIV_D_W'(den_ff);
               state_in  = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Grid memory: one port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_addr] <= mem_wd;
      end
      mem_q <= grid_mem[mem_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         step_ff      <= STEP_RESET;
         span_ff      <= SPAN_RESET;
         low_ff       <= '0;
         high_ff      <= '0;
         pend_ff      <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_STEP: step_ff <= csr_wdata[15:0];
               CSR_SPAN: span_ff <= csr_wdata;
               default:  step_ff <= step_ff;
            endcase
         end
         // The extremes track the unrounded height of every accepted write.
         if (state_ff == S_DECODE && func_ff == FN_WRITE &&
             is_inside($signed(COORD_W'(x_ff)), $signed(COORD_W'(y_ff)))) begin
            if (h_ff < low_ff) begin
               if (26'(high_ff) - 26'(h_ff) < $signed(26'(span_ff))) begin
                  low_ff <= h_ff;
               end
            end else if (h_ff > high_ff) begin
               if (26'(h_ff) - 26'(low_ff) < $signed(26'(span_ff))) begin
                  high_ff <= h_ff;
               end
            end
         end
         pend_ff <= (state_ff == S_READ);
         if (state_ff == S_READ) begin
            slot_ff <= slot_ff + 3'd1;
         end else begin
            slot_ff <= '0;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      logic signed [25:0] nsum;
      logic signed [25:0] navg;
      nsum = 26'(v_ff[1]) + 26'(v_ff[2]) + 26'(v_ff[3]) + 26'(v_ff[4]);
      navg = (!xe && !ye) ? (nsum >>> 2) : (nsum >>> 1);
      if (req_fire) begin
         func_ff <= req_chan.func;
         x_ff    <= req_chan.x_int;
         y_ff    <= req_chan.y_int;
         dx_ff   <= req_chan.x_frac;
         dy_ff   <= req_chan.y_frac;
         h_ff    <= req_chan.write_height;
         sp_ff   <= req_chan.spacing;
      end
      pin_ff   <= slot_in;
      pslot_ff <= slot_ff;
      if (pend_ff) begin
         v_ff[pslot_ff] <= pin_ff ? $signed(mem_q) : '0;
      end
      unique case (state_ff)
         S_DECODE: begin
            res_ff    <= '0;
            status_ff <= STAT_DONE;
            waddr_ff  <= ADDR_W'(ADDR_W'(y_ff[IDX_W-1:0]) * ADDR_W'(SIDE))
                         + ADDR_W'(x_ff[IDX_W-1:0]);
            prod_ff   <= 43'(h_ff);
            case (func_ff)
               FN_WRITE, FN_READ: begin
                  if (!is_inside($signed(COORD_W'(x_ff)), $signed(COORD_W'(y_ff)))) begin
                     status_ff <= STAT_OUTSIDE;
                  end else if (func_ff == FN_WRITE &&
                               ((h_ff < low_ff &&
                                 !(26'(high_ff) - 26'(h_ff) < $signed(26'(span_ff)))) ||
                                (h_ff >= low_ff && h_ff > high_ff &&
                                 !(26'(h_ff) - 26'(low_ff) < $signed(26'(span_ff)))))) begin
                     status_ff <= STAT_REJECT;
                  end
               end
               FN_TRI, FN_BILIN: begin
                  if (!(x_ff < 10'(GRID_SIZE) && y_ff < 10'(GRID_SIZE))) begin
                     status_ff <= STAT_OUTSIDE;
                  end
               end
               FN_MORPH: begin
                  if (!is_inside($signed(COORD_W'(x_ff)), $signed(COORD_W'(y_ff)))) begin
                     status_ff <= STAT_OUTSIDE;
                  end
               end
               default: begin
                  status_ff <= STAT_DONE;
               end
            endcase
         end
         S_LERP: begin
            case (func_ff)
               FN_READ: begin
                  res_ff <= 28'(v_ff[0]);
               end
               FN_MORPH: begin
                  res_ff <= (xe && ye) ? '0 : 28'(navg) - 28'(v_ff[0]);
               end
               default: begin
                  // Slots: v0 origin, v1 right, v2 below, v3 diagonal corner.
                  if (func_ff == FN_BILIN) begin
                     h1_ff  <= lerp_dy(v_ff[0], v_ff[2], dy_ff);
                     h2_ff  <= lerp_dy(v_ff[1], v_ff[3], dy_ff);
                     num_ff <= 9'(dx_ff);
                     den_ff <= 9'(1 << FRAC_BITS);
                     tri_ff <= 1'b0;
                  end else if (9'(dx_ff) + 9'(dy_ff) <= 9'(1 << FRAC_BITS)) begin
                     h1_ff  <= lerp_dy(v_ff[0], v_ff[2], dy_ff);
                     h2_ff  <= lerp_dy(v_ff[1], v_ff[2], dy_ff);
                     num_ff <= 9'(dx_ff);
                     den_ff <= 9'(1 << FRAC_BITS) - 9'(dy_ff);
                     tri_ff <= 1'b1;
                  end else begin
                     h1_ff  <= lerp_dy(v_ff[1], v_ff[2], dy_ff);
                     h2_ff  <= lerp_dy(v_ff[1], v_ff[3], dy_ff);
                     num_ff <= 9'(dx_ff) + 9'(dy_ff) - 9'(1 << FRAC_BITS);
                     den_ff <= 9'(dy_ff);
                     tri_ff <= 1'b1;
                  end
               end
            endcase
         end
         S_MUL: begin
            prod_ff <= 43'(26'(h2_ff) - 26'(h1_ff)) * $signed({1'b0, num_ff});
         end
         S_DIV: begin
            if (div_done && func_ff != FN_WRITE) begin
               res_ff <= 28'(h1_ff) + div_quot[27:0];
            end
         end
         S_WMUL: begin
            // The rounded quotient is negative when twice the height plus the step is negative.
            prod_ff <= 43'($signed(div_quot[26:0])) * $signed({1'b0, step_ff});
         end
         S_STORE: begin
            res_ff <= 28'(sat24(prod_ff));
         end
         S_FINISH: begin
            if (!tri_ff) begin
               res_ff <= 28'(h1_ff) + 28'(prod_ff >>> FRAC_BITS);
            end
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
      if (state_ff == S_DONE && out_free) begin
         rsp_h_ff    <= sat25(43'(res_ff));
         rsp_stat_ff <= status_ff;
         rsp_min_ff  <= low_ff;
         rsp_max_ff  <= high_ff;
      end
   end

   hms_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.height_out = rsp_h_ff;
   assign rsp_chan.status     = rsp_stat_ff;
   assign rsp_chan.min_height = rsp_min_ff;
   assign rsp_chan.max_height = rsp_max_ff;

   // The accepted extremes never cross.
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      low_ff <= high_ff)
      else $error("lowest accepted height exceeds highest");

   // No request is taken while the clearing pass runs.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_chan.ready)
      else $error("request accepted during grid clear");

   // The grid is only written by the clearing pass or a write request.
   a_mem_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || (state_ff == S_STORE && func_ff == FN_WRITE)))
      else $error("unexpected grid memory write");

   // A rejected write reports a zero height.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff == STAT_REJECT |-> rsp_h_ff == '0)
      else $error("rejected write returned a height");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import hms_pkg::*;

   // One request as the driver presents it on the request channel.
   typedef struct {
      logic [2:0]         func;
      logic [9:0]         x_int;
      logic [9:0]         y_int;
      logic [7:0]         x_frac;
      logic [7:0]         y_frac;
      logic signed [23:0] write_height;
      logic [9:0]         spacing;
   } height_req_type;

   // One response as the block should return it.
   typedef struct {
      logic signed [24:0] height_out;
      logic [1:0]         status;
      logic signed [23:0] min_height;
      logic signed [23:0] max_height;
   } height_rsp_type;

   localparam longint UNIT        = longint'(1) << FRAC_BITS;
   localparam int     IDLE_LIMIT  = 200000;
   localparam int     DRAIN_WAIT  = 60;
   localparam int     PHASES      = 7;
   localparam int     PHASE_ITEMS = 250;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [22:0] csr_wdata;

   hms_req_if req_bus ();
   hms_rsp_if rsp_bus ();

   heightmap_store_and_sampler uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The driver pulls requests from pending_reqs; every accepted request
   // pushes its predicted response onto expected_rsps for the monitor.
   height_req_type pending_reqs[$];
   height_rsp_type expected_rsps[$];

   // Private copy of the block's state and registers.
   logic signed [23:0] grid_copy [DEPTH];
   longint             lowest_copy;
   longint             highest_copy;
   longint             step_copy;
   longint             span_copy;

   int  mismatch_count;
   int  rsp_count;
   int  reject_count;
   int  outside_count;
   bit  no_gaps;          // set during phases that run without idling
   int  idle_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint floor_div(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic bit on_grid(longint x, longint y);
      return x >= 0 && y >= 0 && x <= GRID_SIZE && y <= GRID_SIZE;
   endfunction

   // Entries off the grid read as zero, as the block does for neighbours.
   function automatic longint grid_at(longint x, longint y);
      if (!on_grid(x, y)) return 0;
      return longint'(grid_copy[y * SIDE + x]);
   endfunction

   function automatic longint blend(longint a, longint b, longint num, longint den);
      return a + floor_div((b - a) * num, den);
   endfunction

   // Works out the response for one accepted request and updates the state copy.
   function automatic void predict_height(height_req_type r);
      height_rsp_type e;
      longint x, y, dx, dy, h, sp, res, q, v0, v1, v2, v3, h1, h2, avg;
      bit ok;
      x   = r.x_int;
      y   = r.y_int;
      dx  = r.x_frac;
      dy  = r.y_frac;
      h   = r.write_height;
      sp  = r.spacing;
      res = 0;
      e.status = STAT_DONE;
      case (r.func)
         FN_WRITE: begin
            if (!on_grid(x, y)) begin
               e.status = STAT_OUTSIDE;
            end else begin
               ok = 1'b1;
               // The span check uses the unrounded height, and so do the bounds.
               if (h < lowest_copy) begin
                  if (highest_copy - h < span_copy) lowest_copy = h;
                  else ok = 1'b0;
               end else if (h > highest_copy) begin
                  if (h - lowest_copy < span_copy) highest_copy = h;
                  else ok = 1'b0;
               end
               if (!ok) begin
                  e.status = STAT_REJECT;
               end else begin
                  q = h;
                  if (step_copy != 0)
                     q = floor_div(2 * h + step_copy, 2 * step_copy) * step_copy;
                  if (q > 8388607) q = 8388607;
                  if (q < -8388608) q = -8388608;
                  grid_copy[y * SIDE + x] = q[23:0];
                  res = q;
               end
            end
         end
         FN_READ: begin
            if (!on_grid(x, y)) e.status = STAT_OUTSIDE;
            else res = grid_at(x, y);
         end
         FN_TRI, FN_BILIN: begin
            if (x >= GRID_SIZE || y >= GRID_SIZE) begin
               e.status = STAT_OUTSIDE;
            end else begin
               v0 = grid_at(x, y);
               v1 = grid_at(x + 1, y);
               v2 = grid_at(x, y + 1);
               v3 = grid_at(x + 1, y + 1);
               if (r.func == FN_BILIN) begin
                  h1  = blend(v0, v2, dy, UNIT);
                  h2  = blend(v1, v3, dy, UNIT);
                  res = blend(h1, h2, dx, UNIT);
               end else if (dx + dy <= UNIT) begin
                  h1  = blend(v0, v2, dy, UNIT);
                  h2  = blend(v1, v2, dy, UNIT);
                  res = blend(h1, h2, dx, UNIT - dy);
               end else begin
                  h1  = blend(v1, v2, dy, UNIT);
                  h2  = blend(v1, v3, dy, UNIT);
                  res = blend(h1, h2, dx + dy - UNIT, dy);
               end
            end
         end
         FN_MORPH: begin
            // The value is still formed when the center is off the grid.
            if (!on_grid(x, y)) e.status = STAT_OUTSIDE;
            if (x[0] || y[0]) begin
               if (!x[0])
                  avg = floor_div(grid_at(x, y - sp) + grid_at(x, y + sp), 2);
               else if (!y[0])
                  avg = floor_div(grid_at(x - sp, y) + grid_at(x + sp, y), 2);
               else
                  avg = floor_div(grid_at(x - sp, y - sp) + grid_at(x + sp, y + sp) +
                                  grid_at(x - sp, y + sp) + grid_at(x + sp, y - sp), 4);
               res = avg - grid_at(x, y);
            end
         end
         default: ;
      endcase
      if (res > 16777215) res = 16777215;
      if (res < -16777216) res = -16777216;
      e.height_out = res[24:0];
      e.min_height = lowest_copy[23:0];
      e.max_height = highest_copy[23:0];
      expected_rsps.push_back(e);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("MISMATCH response %0d: %s got %0d, want %0d", rsp_count, what, got, want);
   endtask

   function automatic int draw_gap();
      if (no_gaps) return 0;
      return $urandom_range(0, 17);
   endfunction

   // Coordinates cluster in a small corner so that samples and reads meet
   // written entries, with the grid edges and the full field range mixed in.
   function automatic logic [9:0] pick_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 10'($urandom_range(0, 7));
         6:                return 10'($urandom_range(248, 257));
         7:                return 10'($urandom_range(0, 1023));
         8:                return 10'($urandom_range(0, GRID_SIZE));
         default:          return 10'($urandom_range(255, 258));
      endcase
   endfunction

   function automatic logic signed [23:0] pick_height();
      case ($urandom_range(0, 5))
         0, 1:    return 24'($signed($urandom_range(0, 4000)) - 2000);
         2:       return 24'($urandom);
         3:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         default: return 24'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   function automatic height_req_type random_req();
      height_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      r.func = FN_WRITE;
      else if (pick < 50) r.func = FN_READ;
      else if (pick < 65) r.func = FN_TRI;
      else if (pick < 80) r.func = FN_BILIN;
      else if (pick < 95) r.func = FN_MORPH;
      else                r.func = 3'($urandom_range(5, 7));
      r.x_int        = pick_coord();
      r.y_int        = pick_coord();
      r.x_frac       = 8'($urandom);
      r.y_frac       = 8'($urandom);
      r.write_height = pick_height();
      r.spacing      = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 4));
      return r;
   endfunction

   function automatic height_req_type make_req(logic [2:0] f, int x, int y, int xf, int yf,
                                               int h, int sp);
      height_req_type r;
      r.func         = f;
      r.x_int        = 10'(x);
      r.y_int        = 10'(y);
      r.x_frac       = 8'(xf);
      r.y_frac       = 8'(yf);
      r.write_height = 24'(h);
      r.spacing      = 10'(sp);
      return r;
   endfunction

   // Request driver: one item in flight on the channel, gap drawn per item.
   height_req_type drive_item;
   bit             drive_loaded;
   int             drive_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         drive_loaded = 1'b0;
         drive_gap    = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_height(drive_item);
            drive_loaded = 1'b0;
            drive_gap    = draw_gap();
         end
         if (!drive_loaded) begin
            if (drive_gap > 0) begin
               drive_gap--;
            end else if (pending_reqs.size() > 0) begin
               drive_item   = pending_reqs.pop_front();
               drive_loaded = 1'b1;
            end
         end
         req_bus.valid        <= drive_loaded;
         req_bus.func         <= drive_item.func;
         req_bus.x_int        <= drive_item.x_int;
         req_bus.y_int        <= drive_item.y_int;
         req_bus.x_frac       <= drive_item.x_frac;
         req_bus.y_frac       <= drive_item.y_frac;
         req_bus.write_height <= drive_item.write_height;
         req_bus.spacing      <= drive_item.spacing;
      end
   end

   // Response monitor: compares against the oldest prediction, stalls at random.
   int rsp_stall;

   always @(posedge clock) begin
      height_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with nothing expected, height_out",
                               rsp_bus.height_out, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_bus.height_out !== want.height_out)
                  report_mismatch("height_out", rsp_bus.height_out, want.height_out);
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", rsp_bus.status, want.status);
               if (rsp_bus.min_height !== want.min_height)
                  report_mismatch("min_height", rsp_bus.min_height, want.min_height);
               if (rsp_bus.max_height !== want.max_height)
                  report_mismatch("max_height", rsp_bus.max_height, want.max_height);
               if (want.status == STAT_REJECT) reject_count++;
               if (want.status == STAT_OUTSIDE) outside_count++;
            end
            rsp_stall = draw_gap();
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_bus.ready <= (rsp_stall == 0);
      end
   end

   // The watchdog covers the clearing pass after reset as well as a hang.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic wait_quiet();
      while (pending_reqs.size() > 0 || drive_loaded || req_bus.valid ||
             expected_rsps.size() > 0)
         @(posedge clock);
      // Then let the block idle before the registers change.
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 23'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_STEP) step_copy = value & 16'hFFFF;
      else span_copy = value & 23'h7FFFFF;
   endtask

   // Register settings per phase, the extremes and a zero step among them.
   int unsigned step_plan [PHASES] = '{13, 1, 65535, 0, 40000, 7, 256};
   int unsigned span_plan [PHASES] = '{2560000, 8388607, 8388607, 1, 8388607, 300000, 1000};

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_STEP;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.func   = FN_READ;
      req_bus.x_int  = '0;
      req_bus.y_int  = '0;
      req_bus.x_frac = '0;
      req_bus.y_frac = '0;
      req_bus.write_height = '0;
      req_bus.spacing = '0;
      rsp_bus.ready  = 1'b0;
      idle_cycles    = 0;
      mismatch_count = 0;
      rsp_count      = 0;
      reject_count   = 0;
      outside_count  = 0;
      no_gaps        = 1'b0;
      foreach (grid_copy[i]) grid_copy[i] = '0;
      lowest_copy  = 0;
      highest_copy = 0;
      step_copy    = STEP_RESET;
      span_copy    = SPAN_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         // Each phase starts with the block drained, so the sender has paused
         // until every response came back before the registers change.
         wait_quiet();
         write_csr(CSR_STEP, step_plan[p]);
         write_csr(CSR_SPAN, span_plan[p]);
         no_gaps = (p % 3 == 2);
         if (p == 0) begin
            // Span rejection at the top corner, then writes in range and out of it.
            pending_reqs.push_back(make_req(FN_WRITE, 256, 256, 0, 0, 8388607, 0));
            pending_reqs.push_back(make_req(FN_WRITE, 0, 0, 0, 0, 1000, 0));
            pending_reqs.push_back(make_req(FN_WRITE, 1, 0, 0, 0, -1000, 0));
            pending_reqs.push_back(make_req(FN_WRITE, 0, 1, 0, 0, 507, 0));
            pending_reqs.push_back(make_req(FN_WRITE, 1, 1, 0, 0, -6, 0));
            pending_reqs.push_back(make_req(FN_WRITE, 256, 256, 0, 0, -8388608, 0));
            pending_reqs.push_back(make_req(FN_WRITE, 257, 0, 0, 0, 5, 0));
            pending_reqs.push_back(make_req(FN_WRITE, 1023, 1023, 255, 255, -1, 1023));
            // Raw reads inside and outside the grid.
            pending_reqs.push_back(make_req(FN_READ, 0, 0, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FN_READ, 257, 257, 0, 0, 0, 0));
            // Both triangles, the diagonal itself and the frame corners.
            pending_reqs.push_back(make_req(FN_TRI, 0, 0, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FN_TRI, 0, 0, 200, 200, 0, 0));
            pending_reqs.push_back(make_req(FN_TRI, 0, 0, 128, 128, 0, 0));
            pending_reqs.push_back(make_req(FN_TRI, 0, 0, 255, 1, 0, 0));
            pending_reqs.push_back(make_req(FN_BILIN, 0, 0, 255, 255, 0, 0));
            pending_reqs.push_back(make_req(FN_BILIN, 256, 0, 10, 10, 0, 0));
            pending_reqs.push_back(make_req(FN_TRI, 255, 255, 77, 33, 0, 0));
            // Morph delta: even center, odd x, odd y, both odd, off-grid center
            // and a spacing that underflows the coordinates.
            pending_reqs.push_back(make_req(FN_MORPH, 0, 0, 0, 0, 0, 1));
            pending_reqs.push_back(make_req(FN_MORPH, 1, 0, 0, 0, 0, 1));
            pending_reqs.push_back(make_req(FN_MORPH, 0, 1, 0, 0, 0, 1));
            pending_reqs.push_back(make_req(FN_MORPH, 1, 1, 0, 0, 0, 1));
            pending_reqs.push_back(make_req(FN_MORPH, 257, 3, 0, 0, 0, 2));
            pending_reqs.push_back(make_req(FN_MORPH, 1, 1, 0, 0, 0, 1023));
            // Unused function codes.
            pending_reqs.push_back(make_req(3'd5, 0, 0, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(3'd7, 1023, 1023, 255, 255, -1, 1023));
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            pending_reqs.push_back(random_req());
      end

      wait_quiet();
      $display("covered %0d responses over %0d register settings", rsp_count, PHASES);
      $display("%0d span rejections, %0d off-grid requests", reject_count, outside_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/hms_pkg.sv
hdl/hms_req_if.sv
hdl/hms_rsp_if.sv
hdl/hms_div.sv
hdl/heightmap_store_and_sampler.sv
sim/tb_top.sv
